### rtl/gqt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gqt_pkg: shared types and constants of the group quota throttle table
// Command and status codes, field widths and the controller/datapath links.
// ---------------------------------------------------------------------------
package gqt_pkg;

	localparam int GROUPS_DEF = 16;

	localparam int CMD_W   = 3;
	localparam int GID_W   = 4;
	localparam int AMT_W   = 64;
	localparam int STS_W   = 2;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 72;

	localparam logic [CMD_W-1:0] OP_ALLOC     = 3'd0;
	localparam logic [CMD_W-1:0] OP_SET_LIMIT = 3'd1;
	localparam logic [CMD_W-1:0] OP_ACCOUNT   = 3'd2;
	localparam logic [CMD_W-1:0] OP_QUERY     = 3'd3;
	localparam logic [CMD_W-1:0] OP_RESET_WIN = 3'd4;

	localparam logic [STS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STS_W-1:0] ST_BADGRP = 2'd1;
	localparam logic [STS_W-1:0] ST_FULL   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic idle;
		logic take;
		logic exec;
		logic scan_inc;
		logic claim;
		logic full;
	} gqt_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic in_alloc;
		logic out_free;
		logic scan_free;
		logic scan_last;
	} gqt_sts_t;

endpackage

### rtl/group_quota_throttle_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// group_quota_throttle_table: usage groups with quotas and throttling
// Table of GROUPS slots, each with used mark, usage, limit and throttle flag.
// ---------------------------------------------------------------------------
// Usage:
//   slave channel s_*: one command per beat, s_tuser = cmd, s_tdata holds
//   group_id and amount. master channel m_*: one result beat per command.
//   Commands are taken one at a time; s_tready is high only while the
//   sequencer waits for a new command.
//   set_limit, account, query, reset_window and bad commands are accepted
//   with a read of the usage/limit memories, then executed and written
//   back. alloc claims the lowest free slot (1 to GROUPS-1), found by a
//   one-slot-per-cycle scan; a full table gives full status.
//   Results go to an output register, so the next command is accepted while
//   a result still waits. When the receiver stalls with a result pending,
//   the next command holds in its final cycle until the register frees.
//   Reset clears all used, throttle and memory valid bits at once: every
//   group reads as zero usage and no limit; no clearing pass is needed.
// ---------------------------------------------------------------------------
module group_quota_throttle_table #(
	parameter int GROUPS = gqt_pkg::GROUPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gqt_pkg::S_TDATA_W-1:0]   s_tdata,  // group_id[3:0], amount[67:4]
	input  logic [gqt_pkg::CMD_W-1:0]       s_tuser,  // cmd[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gqt_pkg::M_TDATA_W-1:0]   m_tdata   // status[1:0], new_group[5:2],
	                                                  // throttled[6], usage[70:7]
);
	import gqt_pkg::*;

	gqt_ctl_t ctl;
	gqt_sts_t sts;

	gqt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	gqt_dpath #(
		.GROUPS (GROUPS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.ctl      (ctl),
		.sts      (sts)
	);

	// one command in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while previous one still in work");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.exec, ctl.claim, ctl.full, ctl.scan_inc}))
		else $error("more than one sequencer action in a cycle");

	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.claim |-> sts.scan_free && sts.out_free)
		else $error("claim of a used slot or into a busy result register");

	a_full_no_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_FULL) |-> (m_tdata[6:2] == '0))
		else $error("full status carries a group or throttle bit");

endmodule

### rtl/gqt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gqt_ctrl: sequencer of the group quota throttle table
// Accepts one command at a time, then runs either the execute step
// or the free-slot scan of an alloc.
// ---------------------------------------------------------------------------
module gqt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  gqt_pkg::gqt_sts_t sts,
	output gqt_pkg::gqt_ctl_t ctl
);
	import gqt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				ctl.idle = 1'b1;
				if (s_tvalid) begin
					ctl.take = 1'b1;
					state_d  = sts.in_alloc ? S_SCAN : S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					ctl.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.scan_free) begin
					if (sts.out_free) begin
						ctl.claim = 1'b1;
						state_d   = S_IDLE;
					end
				end else if (sts.scan_last) begin
					if (sts.out_free) begin
						ctl.full = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					ctl.scan_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/gqt_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gqt_dpath: group table storage and arithmetic
// Usage and limit memories with per-entry valid bits, used and throttle
// flags, saturating accumulate, limit compare and the result register.
// ---------------------------------------------------------------------------
module gqt_dpath #(
	parameter int GROUPS = gqt_pkg::GROUPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [gqt_pkg::CMD_W-1:0]       s_tuser,
	input  logic [gqt_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gqt_pkg::M_TDATA_W-1:0]   m_tdata,
	input  gqt_pkg::gqt_ctl_t               ctl,
	output gqt_pkg::gqt_sts_t               sts
);
	import gqt_pkg::*;

	localparam int IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CMP_W = IDX_W + GID_W + 1;

	logic [GID_W-1:0] in_id;
	logic [AMT_W-1:0] in_amt;

	logic [CMD_W-1:0] req_cmd_q;
	logic [GID_W-1:0] req_id_q;
	logic [AMT_W-1:0] req_amt_q;
	logic [IDX_W-1:0] req_idx;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] scan_q;

	logic [GROUPS-1:0] used_q;
	logic [GROUPS-1:0] thr_q;
	logic [GROUPS-1:0] cnt_vld_q;
	logic [GROUPS-1:0] lim_vld_q;

	logic [AMT_W-1:0] cnt_mem [GROUPS];
	logic [AMT_W-1:0] lim_mem [GROUPS];
	logic [AMT_W-1:0] cnt_rd_q;
	logic [AMT_W-1:0] lim_rd_q;

	logic             g_ok;
	logic [AMT_W-1:0] cur_cnt;
	logic [AMT_W-1:0] cur_lim;
	logic [AMT_W:0]   acc_sum;
	logic [AMT_W-1:0] acc_cnt;
	logic             acc_over;
	logic             set_over;
	logic             cnt_we;
	logic             lim_we;
	logic             rst_win;

	logic [STS_W-1:0] res_sts;
	logic [GID_W-1:0] res_grp;
	logic             res_thr;
	logic [AMT_W-1:0] res_usage;
	logic             load_out;

	logic             out_vld_q;
	logic [STS_W-1:0] out_sts_q;
	logic [GID_W-1:0] out_grp_q;
	logic             out_thr_q;
	logic [AMT_W-1:0] out_usage_q;

	assign in_id  = s_tdata[GID_W-1:0];
	assign in_amt = s_tdata[GID_W +: AMT_W];

	assign req_idx = IDX_W'(req_id_q);
	// the read is issued while idle so data is ready in the execute cycle
	assign rd_idx  = ctl.idle ? IDX_W'(in_id) : req_idx;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			req_cmd_q <= s_tuser;
			req_id_q  <= in_id;
			req_amt_q <= in_amt;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[req_idx] <= acc_cnt;
		end
		cnt_rd_q <= cnt_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (lim_we) begin
			lim_mem[req_idx] <= req_amt_q;
		end
		lim_rd_q <= lim_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctl.take) begin
			scan_q <= IDX_W'(1);
		end else if (ctl.scan_inc) begin
			scan_q <= scan_q + IDX_W'(1);
		end
	end

	assign g_ok = (CMP_W'(req_id_q) < CMP_W'(GROUPS)) &&
		((req_id_q == '0) || used_q[req_idx]);

	assign cur_cnt  = cnt_vld_q[req_idx] ? cnt_rd_q : '0;
	assign cur_lim  = lim_vld_q[req_idx] ? lim_rd_q : '0;
	assign acc_sum  = {1'b0, cur_cnt} + {1'b0, req_amt_q};
	assign acc_cnt  = acc_sum[AMT_W] ? '1 : acc_sum[AMT_W-1:0];
	assign acc_over = (cur_lim != '0) && (acc_cnt >= cur_lim);
	assign set_over = (req_amt_q != '0) && (cur_cnt >= req_amt_q);
	assign rst_win  = ctl.exec && (req_cmd_q == OP_RESET_WIN);

	always_comb begin
		res_sts   = ST_OK;
		res_grp   = '0;
		res_thr   = 1'b0;
		res_usage = '0;
		cnt_we    = 1'b0;
		lim_we    = 1'b0;
		if (ctl.claim) begin
			res_grp = GID_W'(scan_q);
		end else if (ctl.full) begin
			res_sts = ST_FULL;
		end else begin
			case (req_cmd_q)
				OP_SET_LIMIT: begin
					if (g_ok) begin
						lim_we    = ctl.exec;
						res_usage = cur_cnt;
					end else begin
						res_sts = ST_BADGRP;
					end
				end
				OP_ACCOUNT: begin
					if (g_ok) begin
						cnt_we    = ctl.exec;
						res_usage = acc_cnt;
					end else begin
						res_sts = ST_BADGRP;
					end
				end
				OP_QUERY: begin
					if (g_ok) begin
						res_thr   = (req_id_q != '0) && thr_q[req_idx];
						res_usage = cur_cnt;
					end else begin
						res_sts = ST_BADGRP;
					end
				end
				OP_RESET_WIN: begin
					res_sts = ST_OK;
				end
				default: begin
					res_sts = ST_BADGRP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			thr_q     <= '0;
			cnt_vld_q <= '0;
			lim_vld_q <= '0;
		end else begin
			// window reset: drop usage and throttle flag of every used slot but the default group
			if (rst_win) begin
				for (int i = 1; i < GROUPS; i++) begin
					if (used_q[i]) begin
						cnt_vld_q[i] <= 1'b0;
						thr_q[i]     <= 1'b0;
					end
				end
			end
			if (ctl.claim) begin
				used_q[scan_q]    <= 1'b1;
				cnt_vld_q[scan_q] <= 1'b0;
				lim_vld_q[scan_q] <= 1'b0;
				thr_q[scan_q]     <= 1'b0;
			end
			if (lim_we) begin
				lim_vld_q[req_idx] <= 1'b1;
				thr_q[req_idx]     <= set_over;
			end
			if (cnt_we) begin
				cnt_vld_q[req_idx] <= 1'b1;
				if (acc_over) begin
					thr_q[req_idx] <= 1'b1;
				end
			end
		end
	end

	assign load_out = ctl.exec || ctl.claim || ctl.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sts_q   <= res_sts;
			out_grp_q   <= res_grp;
			out_thr_q   <= res_thr;
			out_usage_q <= res_usage;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_usage_q, out_thr_q, out_grp_q, out_sts_q};

	assign sts.in_alloc  = (s_tuser == OP_ALLOC);
	assign sts.out_free  = !out_vld_q || m_tready;
	assign sts.scan_free = !used_q[scan_q];
	assign sts.scan_last = (scan_q == IDX_W'(GROUPS - 1));

endmodule

### verif/gqt_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gqt_result_checker: result checker for the group quota throttle table
// Tracks the group table from accepted command beats, queues the result each
// command should give and compares every result beat field by field.
// ---------------------------------------------------------------------------
module gqt_result_checker #(
	parameter int GROUPS = gqt_pkg::GROUPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [gqt_pkg::S_TDATA_W-1:0]   s_tdata,  // group_id[3:0], amount[67:4]
	input  logic [gqt_pkg::CMD_W-1:0]       s_tuser,  // cmd[2:0]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [gqt_pkg::M_TDATA_W-1:0]   m_tdata,  // status[1:0], new_group[5:2],
	                                                  // throttled[6], usage[70:7]
	output int                              awaited,
	output int                              errors
);
	import gqt_pkg::*;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [GID_W-1:0] new_group;
		logic             throttled;
		logic [AMT_W-1:0] usage;
	} grp_result_t;

	logic             used     [GROUPS];
	logic [AMT_W-1:0] usage_of [GROUPS];
	logic [AMT_W-1:0] quota    [GROUPS];
	logic             throttle [GROUPS];
	grp_result_t      pending_results [$];

	function automatic logic grp_ok(input logic [GID_W-1:0] gid);
		return (gid < GROUPS) && (gid == 0 || used[gid]);
	endfunction

	// advance the table by one command and give the result it should produce
	task automatic table_step(input logic [CMD_W-1:0] op, input logic [GID_W-1:0] gid,
			input logic [AMT_W-1:0] amt, output grp_result_t r);
		logic [AMT_W:0] sum;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_ALLOC: begin
				r.status = ST_FULL;
				for (int i = 1; i < GROUPS; i++) begin
					if (!used[i] && r.status == ST_FULL) begin
						used[i] = 1'b1;
						usage_of[i] = '0;
						quota[i] = '0;
						throttle[i] = 1'b0;
						r.status = ST_OK;
						r.new_group = GID_W'(i);
					end
				end
			end
			OP_SET_LIMIT: begin
				if (!grp_ok(gid)) begin
					r.status = ST_BADGRP;
				end else begin
					quota[gid] = amt;
					throttle[gid] = (amt != '0) && (usage_of[gid] >= amt);
					r.usage = usage_of[gid];
				end
			end
			OP_ACCOUNT: begin
				if (!grp_ok(gid)) begin
					r.status = ST_BADGRP;
				end else begin
					sum = {1'b0, usage_of[gid]} + {1'b0, amt};
					// saturate at all ones
					usage_of[gid] = sum[AMT_W] ? '1 : sum[AMT_W-1:0];
					if (quota[gid] != '0 && usage_of[gid] >= quota[gid])
						throttle[gid] = 1'b1;
					r.usage = usage_of[gid];
				end
			end
			OP_QUERY: begin
				if (!grp_ok(gid)) begin
					r.status = ST_BADGRP;
				end else begin
					r.throttled = (gid != 0) && throttle[gid];
					r.usage = usage_of[gid];
				end
			end
			OP_RESET_WIN: begin
				// default group keeps its usage across windows
				for (int i = 1; i < GROUPS; i++) begin
					if (used[i]) begin
						usage_of[i] = '0;
						throttle[i] = 1'b0;
					end
				end
			end
			default: begin
				r.status = ST_BADGRP;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [AMT_W-1:0] want,
			input logic [AMT_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		grp_result_t want;
		grp_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < GROUPS; i++) begin
				used[i] = 1'b0;
				usage_of[i] = '0;
				quota[i] = '0;
				throttle[i] = 1'b0;
			end
			pending_results.delete();
			awaited = 0;
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.new_group = m_tdata[5:2];
				got.throttled = m_tdata[6];
				got.usage = m_tdata[70:7];
				if (pending_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, expected none, actual %h",
						$time, m_tdata);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", AMT_W'(want.status), AMT_W'(got.status));
					check_field("new_group", AMT_W'(want.new_group), AMT_W'(got.new_group));
					check_field("throttled", AMT_W'(want.throttled), AMT_W'(got.throttled));
					check_field("usage", want.usage, got.usage);
				end
			end
			if (s_tvalid && s_tready) begin
				table_step(s_tuser, s_tdata[3:0], s_tdata[67:4], want);
				pending_results.push_back(want);
			end
			awaited = pending_results.size();
		end
	end

endmodule

### verif/group_quota_throttle_table_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// group_quota_throttle_table_test: testbench of the group quota throttle table
// Directed commands over the corner cases, then random command streams under
// three idle patterns; a separate checker predicts and compares each result.
// ---------------------------------------------------------------------------
module group_quota_throttle_table_test;
	import gqt_pkg::*;

	localparam int RAND_ITEMS = 1700;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // group_id[3:0], amount[67:4]
	logic [CMD_W-1:0]     s_tuser  = '0;  // cmd[2:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // status[1:0], new_group[5:2],
	                                      // throttled[6], usage[70:7]
	int                   src_idle_pct  = 30;
	int                   sink_idle_pct = 86;
	int                   awaited;
	int                   errors;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	group_quota_throttle_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gqt_result_checker result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.awaited  (awaited),
		.errors   (errors)
	);

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// one command beat, with random idle cycles ahead of it
	task automatic issue(input logic [CMD_W-1:0] op, input logic [GID_W-1:0] gid,
			input logic [AMT_W-1:0] amt);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W-AMT_W-GID_W){1'b0}}, amt, gid};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
	endtask

	function automatic logic [AMT_W-1:0] pick_ticks();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return AMT_W'($urandom_range(0, 400));
			6:                return {$urandom, $urandom};
			7:                return '1;
			8:                return '1 - AMT_W'($urandom_range(0, 3));
			default:          return AMT_W'(1) << $urandom_range(0, AMT_W-1);
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] pick_limit();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return AMT_W'($urandom_range(1, 1500));
			6:                return '0;
			7:                return {$urandom, $urandom};
			8:                return '1;
			default:          return AMT_W'(1);
		endcase
	endfunction

	task automatic run_random(input int count);
		int roll;
		logic [GID_W-1:0] gid;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			gid = GID_W'($urandom_range(0, 15));
			if (roll < 6)
				issue(OP_ALLOC, gid, {$urandom, $urandom});
			else if (roll < 26)
				issue(OP_SET_LIMIT, gid, pick_limit());
			else if (roll < 61)
				issue(OP_ACCOUNT, gid, pick_ticks());
			else if (roll < 86)
				issue(OP_QUERY, gid, {$urandom, $urandom});
			else if (roll < 94)
				issue(OP_RESET_WIN, gid, {$urandom, $urandom});
			else
				issue(OP_RESET_WIN + CMD_W'($urandom_range(1, 3)), gid, {$urandom, $urandom});
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: default group only, unused slots and unknown commands rejected
		issue(OP_QUERY, 4'd0, '0);
		issue(OP_SET_LIMIT, 4'd5, AMT_W'(7));
		issue(OP_ACCOUNT, 4'd15, '1);
		issue(OP_QUERY, 4'd9, '0);
		for (int k = 1; k <= 3; k++)
			issue(OP_RESET_WIN + CMD_W'(k), 4'd1, '1);

		// first group: saturation, throttle on set_limit
		issue(OP_ALLOC, 4'd0, '0);
		issue(OP_ACCOUNT, 4'd1, '1);
		issue(OP_ACCOUNT, 4'd1, AMT_W'(1));
		issue(OP_SET_LIMIT, 4'd1, AMT_W'(5));
		issue(OP_QUERY, 4'd1, '0);

		// default group throttles internally but never reports it, and keeps usage over a window reset
		issue(OP_SET_LIMIT, 4'd0, AMT_W'(10));
		issue(OP_ACCOUNT, 4'd0, AMT_W'(10));
		issue(OP_QUERY, 4'd0, '0);
		issue(OP_RESET_WIN, 4'd0, '0);
		issue(OP_QUERY, 4'd1, '0);
		issue(OP_QUERY, 4'd0, '0);
		issue(OP_SET_LIMIT, 4'd1, '0);
		issue(OP_QUERY, 4'd1, '0);

		run_random(RAND_ITEMS / 3);
		hold_until_drained();
		src_idle_pct = 86;
		sink_idle_pct = 30;
		run_random(RAND_ITEMS / 3);
		hold_until_drained();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
		hold_until_drained();
		repeat (40) @(negedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
